// ----- design/pzs_pkg.sv -----
// Shared constants, register codes and job flag type for the peak zero suppression block.
package pzs_pkg;

	localparam int SAMPLE_BITS_DEF        = 16;
	localparam int MAX_CHANNEL_LENGTH_DEF = 1024;

	localparam int THR_W      = 16;
	localparam int SHIFT_W    = 11;
	localparam int FILL_W     = 11;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 1;

	localparam int Q_DEPTH = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_THRESHOLD      = 1'b0,
		REG_BASELINE_SHIFT = 1'b1
	} cfg_reg_t;

	// Classification of one pending sample, handed from the front to the back
	typedef struct packed {
		logic is_void;   // sample itself is void
		logic cur_over;  // sample is non-void and over threshold
		logic over1;     // next sample exists and is over threshold
		logic valid1;    // next sample exists and is not void
		logic over2;     // sample after next exists and is over threshold
		logic last;      // final result of the channel
	} job_flags_t;

endpackage

// ----- design/pzs_if.sv -----
// Request channel interfaces for samples in and results out.
interface pzs_sample_if #(
	parameter int SAMPLE_BITS = 16
);
	logic                   valid;
	logic                   ready;
	logic [SAMPLE_BITS-1:0] sample_value;
	logic                   sample_void;
	logic                   last_sample;

	modport source (output valid, sample_value, sample_void, last_sample, input ready);
	modport sink (input valid, sample_value, sample_void, last_sample, output ready);
endinterface

interface pzs_result_if #(
	parameter int SAMPLE_BITS = 16,
	parameter int FILL_W      = 11
);
	logic                   valid;
	logic                   ready;
	logic [SAMPLE_BITS:0]   out_value;
	logic                   out_void;
	logic                   out_last;
	logic [FILL_W-1:0]      filled_count;

	modport source (output valid, out_value, out_void, out_last, filled_count, input ready);
	modport sink (input valid, out_value, out_void, out_last, filled_count, output ready);
endinterface

// ----- design/pzs_queue.sv -----
// Short job queue between the front and the back.
module pzs_queue import pzs_pkg::*; #(
	parameter int WIDTH = 22
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             empty
);

	localparam int AW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int CW = $clog2(Q_DEPTH + 1);

	logic [WIDTH-1:0] mem_q [Q_DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    cnt_q;

	assign full     = (cnt_q == CW'(Q_DEPTH));
	assign empty    = (cnt_q == '0);
	assign pop_data = mem_q[rd_ptr_q];

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Store pushed jobs
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ----- design/pzs_front.sv -----
// Front: accepts samples, keeps the two-sample lookahead and classifies each pending sample.
module pzs_front import pzs_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [THR_W-1:0]       threshold,
	pzs_sample_if.sink             in_ch,
	output logic                   push,
	output job_flags_t             push_flags,
	output logic [SAMPLE_BITS-1:0] push_value,
	input  logic                   q_full
);

	localparam int CMP_W = (SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W;

	logic [SAMPLE_BITS-1:0] w_val_q [3];
	logic                   w_void_q [3];
	logic [1:0]             w_cnt_q;
	logic                   flush_q;

	logic                   accept;
	logic [SAMPLE_BITS-1:0] c_val;
	logic                   c_void;
	logic                   e1;
	logic                   e2;
	logic                   step;

	function automatic logic over_thr(input logic [SAMPLE_BITS-1:0] v, input logic vd,
			input logic [THR_W-1:0] thr);
		return !vd && (CMP_W'(v) > CMP_W'(thr));
	endfunction

	// Stall input while draining the window after a last sample, or while the window and the queue are full
	assign in_ch.ready = !flush_q && ((w_cnt_q != 2'd2) || !q_full);
	assign accept      = in_ch.valid && in_ch.ready;
	assign step        = flush_q && !q_full;

	// Classify the oldest pending sample against its two successors
	always_comb begin
		c_val  = flush_q ? w_val_q[2] : in_ch.sample_value;
		c_void = flush_q ? w_void_q[2] : in_ch.sample_void;
		e1     = flush_q ? (w_cnt_q >= 2'd2) : 1'b1;
		e2     = flush_q ? (w_cnt_q == 2'd3) : 1'b1;
		push   = flush_q ? !q_full : (accept && !in_ch.last_sample && (w_cnt_q == 2'd2));

		push_value          = w_val_q[0];
		push_flags.is_void  = w_void_q[0];
		push_flags.cur_over = over_thr(w_val_q[0], w_void_q[0], threshold);
		push_flags.over1    = e1 && over_thr(w_val_q[1], w_void_q[1], threshold);
		push_flags.valid1   = e1 && !w_void_q[1];
		push_flags.over2    = e2 && over_thr(c_val, c_void, threshold);
		push_flags.last     = flush_q && (w_cnt_q == 2'd1);
	end

	// Track window fill and drain mode
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_cnt_q <= '0;
			flush_q <= 1'b0;
		end else if (accept) begin
			if (in_ch.last_sample) begin
				w_cnt_q <= w_cnt_q + 1'b1;
				flush_q <= 1'b1;
			end else if (w_cnt_q != 2'd2) begin
				w_cnt_q <= w_cnt_q + 1'b1;
			end
		end else if (step) begin
			w_cnt_q <= w_cnt_q - 1'b1;
			if (w_cnt_q == 2'd1) begin
				flush_q <= 1'b0;
			end
		end
	end

	// Append or shift window samples
	always_ff @(posedge clk) begin
		if (accept) begin
			if (in_ch.last_sample || (w_cnt_q != 2'd2)) begin
				case (w_cnt_q)
					2'd0: begin
						w_val_q[0]  <= in_ch.sample_value;
						w_void_q[0] <= in_ch.sample_void;
					end
					2'd1: begin
						w_val_q[1]  <= in_ch.sample_value;
						w_void_q[1] <= in_ch.sample_void;
					end
					2'd2: begin
						w_val_q[2]  <= in_ch.sample_value;
						w_void_q[2] <= in_ch.sample_void;
					end
					default: begin
					end
				endcase
			end else begin
				w_val_q[0]  <= w_val_q[1];
				w_void_q[0] <= w_void_q[1];
				w_val_q[1]  <= in_ch.sample_value;
				w_void_q[1] <= in_ch.sample_void;
			end
		end else if (step) begin
			w_val_q[0]  <= w_val_q[1];
			w_void_q[0] <= w_void_q[1];
			w_val_q[1]  <= w_val_q[2];
			w_void_q[1] <= w_void_q[2];
		end
	end

endmodule

// ----- design/pzs_back.sv -----
// Back: tracks the open peak, applies the baseline shift and counts kept samples.
module pzs_back import pzs_pkg::*; #(
	parameter int SAMPLE_BITS        = SAMPLE_BITS_DEF,
	parameter int MAX_CHANNEL_LENGTH = MAX_CHANNEL_LENGTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [SHIFT_W-1:0]     baseline_shift,
	input  logic                   q_empty,
	input  job_flags_t             pop_flags,
	input  logic [SAMPLE_BITS-1:0] pop_value,
	output logic                   pop,
	pzs_result_if.source           out_ch
);

	localparam int OW    = SAMPLE_BITS + 1;
	localparam int CNT_W = $clog2(MAX_CHANNEL_LENGTH + 1);

	logic             in_peak_q;
	logic [CNT_W-1:0] kept_q;
	logic             out_valid_q;
	logic [OW-1:0]    out_value_q;
	logic             out_void_q;
	logic             out_last_q;
	logic [FILL_W-1:0] filled_q;

	logic             keep;
	logic             peak_nxt;
	logic             kept_nv;
	logic [CNT_W-1:0] kept_nxt;
	logic [SHIFT_W-1:0] mag;
	logic [OW-1:0]    cur_ext;
	logic [OW-1:0]    mag_ext;
	logic [OW-1:0]    shifted;

	assign pop = !q_empty && (!out_valid_q || out_ch.ready);

	// Decide keep or drop and update peak state
	always_comb begin
		keep     = 1'b0;
		peak_nxt = in_peak_q;
		if (!in_peak_q && pop_flags.cur_over && pop_flags.over1) begin
			peak_nxt = 1'b1;
			keep     = 1'b1;
		end else if (in_peak_q && pop_flags.cur_over) begin
			keep = 1'b1;
		end else if (in_peak_q) begin
			if (pop_flags.over1 || (pop_flags.valid1 && pop_flags.over2)) begin
				keep = 1'b1;
			end else begin
				peak_nxt = 1'b0;
			end
		end
		kept_nv  = keep && !pop_flags.is_void;
		kept_nxt = (kept_nv && (kept_q < CNT_W'(MAX_CHANNEL_LENGTH))) ? kept_q + 1'b1 : kept_q;
	end

	// Apply baseline shift: subtract with floor at zero, or add
	always_comb begin
		mag     = -baseline_shift;
		cur_ext = OW'(pop_value);
		mag_ext = OW'(mag);
		if (baseline_shift[SHIFT_W-1]) begin
			shifted = (cur_ext > mag_ext) ? cur_ext - mag_ext : '0;
		end else begin
			shifted = cur_ext + OW'(baseline_shift);
		end
	end

	// Hold peak state, kept count and result request valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_peak_q   <= 1'b0;
			kept_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				out_valid_q <= 1'b1;
				if (pop_flags.last) begin
					in_peak_q <= 1'b0;
					kept_q    <= '0;
				end else begin
					in_peak_q <= peak_nxt;
					kept_q    <= kept_nxt;
				end
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Load result payload
	always_ff @(posedge clk) begin
		if (pop) begin
			out_value_q <= kept_nv ? shifted : '0;
			out_void_q  <= !kept_nv;
			out_last_q  <= pop_flags.last;
			filled_q    <= pop_flags.last ? FILL_W'(kept_nxt) : '0;
		end
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.out_value    = out_value_q;
	assign out_ch.out_void     = out_void_q;
	assign out_ch.out_last     = out_last_q;
	assign out_ch.filled_count = filled_q;

endmodule

// ----- design/peak_zero_suppression_top.sv -----
// Top level of the peak zero suppression block: config registers, front, queue and back.
//
// Usage: samples of one channel enter on in_ch (valid/ready), highest timebin first,
// with last_sample on the final one. Results leave on out_ch (valid/ready), one per
// sample, in order; filled_count is nonzero only on the result with out_last.
// Registers threshold (index 0) and baseline_shift (index 1) are written through
// cfg_we/cfg_index/cfg_wdata; the user must write them only while the block is idle;
// the block itself does not enforce this. A sample is classified once two more
// samples have arrived (or the channel ends); its result then passes through the queue
// and the output register. Throughput: one sample per cycle while the queue has room
// and no drain is under way. After a last sample the front drains its lookahead window
// of 1 to 3 samples, one per cycle while the queue has room, with in_ch.ready low.
// Reset clears the window, peak state, kept count, queue and output valid;
// both registers return to zero. When out_ch stalls, the output register holds, the
// two-entry queue fills, and then the front stops taking samples.
module peak_zero_suppression_top import pzs_pkg::*; #(
	parameter int SAMPLE_BITS        = SAMPLE_BITS_DEF,
	parameter int MAX_CHANNEL_LENGTH = MAX_CHANNEL_LENGTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	pzs_sample_if.sink            in_ch,
	pzs_result_if.source          out_ch
);

	localparam int JOB_W = $bits(job_flags_t) + SAMPLE_BITS;

	logic [THR_W-1:0]       threshold_q;
	logic [SHIFT_W-1:0]     baseline_shift_q;

	logic                   push;
	job_flags_t             push_flags;
	logic [SAMPLE_BITS-1:0] push_value;
	logic                   q_full;
	logic                   pop;
	logic                   q_empty;
	logic [JOB_W-1:0]       pop_data;
	job_flags_t             pop_flags;
	logic [SAMPLE_BITS-1:0] pop_value;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q      <= '0;
			baseline_shift_q <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_THRESHOLD:      threshold_q      <= cfg_wdata[THR_W-1:0];
				REG_BASELINE_SHIFT: baseline_shift_q <= cfg_wdata[SHIFT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	pzs_front #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.threshold  (threshold_q),
		.in_ch      (in_ch),
		.push       (push),
		.push_flags (push_flags),
		.push_value (push_value),
		.q_full     (q_full)
	);

	pzs_queue #(
		.WIDTH(JOB_W)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data ({push_flags, push_value}),
		.full      (q_full),
		.pop       (pop),
		.pop_data  (pop_data),
		.empty     (q_empty)
	);

	assign pop_flags = job_flags_t'(pop_data[JOB_W-1:SAMPLE_BITS]);
	assign pop_value = pop_data[SAMPLE_BITS-1:0];

	pzs_back #(
		.SAMPLE_BITS        (SAMPLE_BITS),
		.MAX_CHANNEL_LENGTH (MAX_CHANNEL_LENGTH)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.baseline_shift (baseline_shift_q),
		.q_empty        (q_empty),
		.pop_flags      (pop_flags),
		.pop_value      (pop_value),
		.pop            (pop),
		.out_ch         (out_ch)
	);

endmodule

// ----- design/pzs_checker.sv -----
// Port-level checker for the peak zero suppression block and its bind.
module pzs_checker import pzs_pkg::*; #(
	parameter int SAMPLE_BITS        = SAMPLE_BITS_DEF,
	parameter int MAX_CHANNEL_LENGTH = MAX_CHANNEL_LENGTH_DEF
) (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 out_valid,
	input logic                 out_ready,
	input logic [SAMPLE_BITS:0] out_value,
	input logic                 out_void,
	input logic                 out_last,
	input logic [FILL_W-1:0]    filled_count
);

	// Hold a result request until it is taken
	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result request dropped while stalled");

	// Drop the value of a void result
	a_void_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_void |-> out_value == '0)
		else $error("void result carries a value");

	// Report the count only with the last result
	a_fill_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_last |-> filled_count == '0)
		else $error("filled count outside last result");

	// Keep the count within the channel length
	a_fill_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_last |-> 32'(filled_count) <= 32'(MAX_CHANNEL_LENGTH))
		else $error("filled count exceeds channel length");

endmodule

bind peak_zero_suppression_top pzs_checker #(
	.SAMPLE_BITS        (SAMPLE_BITS),
	.MAX_CHANNEL_LENGTH (MAX_CHANNEL_LENGTH)
) u_pzs_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_ch.valid),
	.out_ready    (out_ch.ready),
	.out_value    (out_ch.out_value),
	.out_void     (out_ch.out_void),
	.out_last     (out_ch.out_last),
	.filled_count (out_ch.filled_count)
);

// ----- bench/peak_zero_suppression_top_tb.sv -----
// Self-checking bench for the peak zero suppression top: directed table, then random channels.
module peak_zero_suppression_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import pzs_pkg::*;

	localparam int SB          = SAMPLE_BITS_DEF;
	localparam int DRAIN_WAIT  = 8;
	localparam int MAX_REPORTS = 10;

	typedef struct packed {
		logic [SB:0]       value;
		logic              vd;
		logic              last;
		logic [FILL_W-1:0] count;
	} zs_result_t;

	typedef enum logic {ROW_SAMPLE, ROW_CFG} row_kind_t;

	typedef struct packed {
		row_kind_t   kind;
		cfg_reg_t    sel;
		logic [15:0] data;
		logic        vd;
		logic        last;
		logic        typed;
		zs_result_t  want;
	} stim_row_t;

	localparam zs_result_t LONE_VOID = '{17'd0, 1'b1, 1'b1, 11'd0};
	localparam zs_result_t NO_WANT   = '{17'd0, 1'b0, 1'b0, 11'd0};
	localparam int N_ROWS = 23;

	// Directed requests: extremes, peak open/close, void inside a peak, flushes, shift corners
	localparam stim_row_t DIRECTED [N_ROWS] = '{
		'{ROW_SAMPLE, REG_THRESHOLD,      16'd5,     1'b0, 1'b1, 1'b1, LONE_VOID},
		'{ROW_SAMPLE, REG_THRESHOLD,      16'hFFFF,  1'b1, 1'b1, 1'b1, LONE_VOID},
		'{ROW_CFG,    REG_THRESHOLD,      16'd100,   1'b0, 1'b0, 1'b0, NO_WANT},
		'{ROW_CFG,    REG_BASELINE_SHIFT, 16'h07F6,  1'b0, 1'b0, 1'b0, NO_WANT},
		'{ROW_SAMPLE, REG_THRESHOLD,      16'd200,   1'b0, 1'b0, 1'b0, NO_WANT},
		'{ROW_SAMPLE, REG_THRESHOLD,      16'd300,   1'b0, 1'b0, 1'b0, NO_WANT},
		'{ROW_SAMPLE, REG_THRESHOLD,      16'd50,    1'b0, 1'b0, 1'b0, NO_WANT},
		'{ROW_SAMPLE, REG_THRESHOLD,      16'd400,   1'b0, 1'b0, 1'b0, NO_WANT},
		'{ROW_SAMPLE, REG_THRESHOLD,      16'd20,    1'b0, 1'b0, 1'b0, NO_WANT},
		'{ROW_SAMPLE, REG_THRESHOLD,      16'd900,   1'b1, 1'b0, 1'b0, NO_WANT},
		'{ROW_SAMPLE, REG_THRESHOLD,      16'hFFFF,  1'b0, 1'b0, 1'b0, NO_WANT},
		'{ROW_SAMPLE, REG_THRESHOLD,      16'hFFFF,  1'b0, 1'b0, 1'b0, NO_WANT},
		'{ROW_SAMPLE, REG_THRESHOLD,      16'd0,     1'b0, 1'b0, 1'b0, NO_WANT},
		'{ROW_SAMPLE, REG_THRESHOLD,      16'd0,     1'b0, 1'b0, 1'b0, NO_WANT},
		'{ROW_SAMPLE, REG_THRESHOLD,      16'd150,   1'b0, 1'b1, 1'b0, NO_WANT},
		'{ROW_CFG,    REG_BASELINE_SHIFT, 16'h0400,  1'b0, 1'b0, 1'b0, NO_WANT},
		'{ROW_SAMPLE, REG_THRESHOLD,      16'd101,   1'b0, 1'b0, 1'b0, NO_WANT},
		'{ROW_SAMPLE, REG_THRESHOLD,      16'd150,   1'b0, 1'b1, 1'b0, NO_WANT},
		'{ROW_CFG,    REG_BASELINE_SHIFT, 16'h03FF,  1'b0, 1'b0, 1'b0, NO_WANT},
		'{ROW_SAMPLE, REG_THRESHOLD,      16'hFFFF,  1'b0, 1'b0, 1'b0, NO_WANT},
		'{ROW_SAMPLE, REG_THRESHOLD,      16'hFFFF,  1'b0, 1'b1, 1'b0, NO_WANT},
		'{ROW_CFG,    REG_THRESHOLD,      16'hFFFF,  1'b0, 1'b0, 1'b0, NO_WANT},
		'{ROW_SAMPLE, REG_THRESHOLD,      16'hFFFF,  1'b0, 1'b1, 1'b1, LONE_VOID}
	};

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	cfg_reg_t              cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	pzs_sample_if #(.SAMPLE_BITS(SB)) in_ch ();
	pzs_result_if #(.SAMPLE_BITS(SB), .FILL_W(FILL_W)) out_ch ();

	peak_zero_suppression_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	// Predictor copy of registers and channel state
	logic [15:0]      thr_q;
	logic [10:0]      shift_q;
	logic [15:0]      win_val [2];
	logic             win_void [2];
	int               win_fill;
	bit               peak_open;
	int               kept_so_far;
	zs_result_t       pending_results [$];

	int  mismatches;
	int  samples_sent;
	int  channels_sent;
	int  results_checked;
	int  settings_used;
	bit  send_burst;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#20_000_000;
		$display("timeout with %0d results still due", pending_results.size());
		$display("peak_zero_suppression_top_tb failed");
		$finish;
	end

	function automatic int idle_gap();
		int r;
		if (send_burst)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// Decide keep or suppress for one sample, given up to two samples of lookahead
	function automatic zs_result_t judge_sample(logic [15:0] v, logic vd,
			bit e1, logic [15:0] v1, logic d1, bit e2, logic [15:0] v2, logic d2);
		logic [15:0] cur;
		bit          over1;
		bit          over2;
		bit          keep;
		int          sh;
		int          outv;
		zs_result_t  r;
		cur   = vd ? 16'd0 : v;
		over1 = e1 && !d1 && (v1 > thr_q);
		over2 = e2 && !d2 && (v2 > thr_q);
		if (!peak_open && cur > thr_q && over1) begin
			peak_open = 1'b1;
			keep = 1'b1;
		end else if (peak_open && cur > thr_q) begin
			keep = 1'b1;
		end else if (peak_open) begin
			keep = over1 || (e1 && !d1 && over2);
			if (!keep)
				peak_open = 1'b0;
		end else begin
			keep = 1'b0;
		end
		r = '{17'd0, 1'b1, 1'b0, 11'd0};
		if (!vd && keep) begin
			sh = int'($signed(shift_q));
			if (sh < 0)
				outv = (int'(cur) > -sh) ? int'(cur) + sh : 0;
			else
				outv = int'(cur) + sh;
			r.value = outv[SB:0];
			r.vd = 1'b0;
			if (kept_so_far < MAX_CHANNEL_LENGTH_DEF)
				kept_so_far++;
		end
		return r;
	endfunction

	// Advance the predictor by one accepted sample and queue the results it releases
	task automatic suppress_sample(logic [15:0] v, logic vd, logic last);
		logic [15:0] vals [3];
		logic        voids [3];
		zs_result_t  r;
		int          n;
		bit          e1;
		bit          e2;
		if (!last) begin
			if (win_fill < 2) begin
				win_val[win_fill] = v;
				win_void[win_fill] = vd;
				win_fill++;
			end else begin
				r = judge_sample(win_val[0], win_void[0], 1'b1, win_val[1], win_void[1],
					1'b1, v, vd);
				pending_results.push_back(r);
				win_val[0] = win_val[1];
				win_void[0] = win_void[1];
				win_val[1] = v;
				win_void[1] = vd;
			end
		end else begin
			for (int j = 0; j < win_fill; j++) begin
				vals[j] = win_val[j];
				voids[j] = win_void[j];
			end
			vals[win_fill] = v;
			voids[win_fill] = vd;
			n = win_fill + 1;
			// Flush the window: lookahead past the end never counts
			for (int j = 0; j < n; j++) begin
				e1 = (j + 1 < n);
				e2 = (j + 2 < n);
				r = judge_sample(vals[j], voids[j],
					e1, e1 ? vals[j + 1] : 16'd0, e1 ? voids[j + 1] : 1'b0,
					e2, e2 ? vals[j + 2] : 16'd0, e2 ? voids[j + 2] : 1'b0);
				if (j == n - 1) begin
					r.last = 1'b1;
					r.count = kept_so_far[FILL_W-1:0];
				end
				pending_results.push_back(r);
			end
			win_fill = 0;
			win_val[0] = '0;
			win_val[1] = '0;
			win_void[0] = 1'b0;
			win_void[1] = 1'b0;
			peak_open = 1'b0;
			kept_so_far = 0;
			channels_sent++;
		end
	endtask

	// Offer one sample request and hold it until accepted
	task automatic feed_sample(logic [15:0] v, logic vd, logic last);
		int gap;
		gap = idle_gap();
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid        <= 1'b1;
		in_ch.sample_value <= v;
		in_ch.sample_void  <= vd;
		in_ch.last_sample  <= last;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		suppress_sample(v, vd, last);
		samples_sent++;
	endtask

	// Drop valid and wait until every due result has left, plus a tail
	task automatic settle_block(int tail);
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (tail) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t sel, logic [15:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= sel;
		cfg_wdata <= data;
		@(posedge clk);
		case (sel)
			REG_THRESHOLD:      thr_q = data;
			REG_BASELINE_SHIFT: shift_q = data[10:0];
			default: ;
		endcase
		cfg_we <= 1'b0;
		@(posedge clk);
		settings_used++;
	endtask

	// One channel: mostly values straddling the threshold, or raw noise
	task automatic run_channel(int len, bit noise, int hold_at);
		int          t;
		logic [15:0] v;
		logic        vd;
		for (int i = 0; i < len; i++) begin
			if (i == hold_at)
				settle_block(0);
			if (noise) begin
				v  = 16'($urandom_range(0, 65535));
				vd = 1'($urandom_range(0, 1));
			end else begin
				vd = ($urandom_range(0, 99) < 12);
				if ($urandom_range(0, 1))
					t = int'(thr_q) + 1 + $urandom_range(0, 300);
				else
					t = int'(thr_q) - $urandom_range(0, 300);
				if (t > 65535)
					t = 65535;
				if (t < 0)
					t = 0;
				v = t[15:0];
			end
			feed_sample(v, vd, i == len - 1);
		end
	endtask

	// Result sink: runs of ready, short stalls, now and then a long one
	initial begin
		int stall;
		out_ch.ready <= 1'b0;
		@(posedge clk);
		forever begin
			out_ch.ready <= 1'b1;
			if ($urandom_range(0, 99) < 15)
				repeat ($urandom_range(30, 80)) @(posedge clk);
			else
				repeat ($urandom_range(1, 6)) @(posedge clk);
			stall = $urandom_range(0, 99) < 55 ? 0 :
				($urandom_range(0, 99) < 90 ? $urandom_range(1, 8) : $urandom_range(20, 60));
			if (stall > 0) begin
				out_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
		end
	end

	// Compare each accepted result request with the oldest prediction
	always @(posedge clk) begin
		zs_result_t got;
		zs_result_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got = '{out_ch.out_value, out_ch.out_void, out_ch.out_last, out_ch.filled_count};
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: unexpected result value=%0d void=%0b last=%0b count=%0d",
						$realtime, got.value, got.vd, got.last, got.count);
			end else begin
				want = pending_results.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display({"%0t: result %0d: expected value=%0d void=%0b last=%0b ",
							"count=%0d, got value=%0d void=%0b last=%0b count=%0d"},
							$realtime, results_checked, want.value, want.vd, want.last,
							want.count, got.value, got.vd, got.last, got.count);
				end
			end
			results_checked++;
		end
	end

	initial begin
		int          len;
		bit          noise;
		logic [15:0] thr_pick [6];
		logic [10:0] shift_pick [6];
		stim_row_t   row;
		arst_n             <= 1'b0;
		cfg_we             <= 1'b0;
		cfg_index          <= REG_THRESHOLD;
		cfg_wdata          <= '0;
		in_ch.valid        <= 1'b0;
		in_ch.sample_value <= '0;
		in_ch.sample_void  <= 1'b0;
		in_ch.last_sample  <= 1'b0;
		thr_q       = '0;
		shift_q     = '0;
		win_fill    = 0;
		win_val[0]  = '0;
		win_val[1]  = '0;
		win_void[0] = 1'b0;
		win_void[1] = 1'b0;
		peak_open   = 1'b0;
		kept_so_far = 0;
		mismatches  = 0;
		samples_sent = 0;
		channels_sent = 0;
		results_checked = 0;
		settings_used = 0;
		send_burst  = 1'b0;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the directed table; typed rows replace the prediction
		for (int k = 0; k < N_ROWS; k++) begin
			row = DIRECTED[k];
			if (row.kind == ROW_CFG) begin
				settle_block(DRAIN_WAIT);
				write_reg(row.sel, row.data);
			end else begin
				feed_sample(row.data, row.vd, row.last);
				if (row.typed) begin
					void'(pending_results.pop_back());
					pending_results.push_back(row.want);
				end
			end
		end

		// Register settings for the random phases, extremes first
		thr_pick   = '{16'd0, 16'hFFFF, 16'd500, 16'd30000, 16'($urandom), 16'd1000};
		shift_pick = '{11'h000, 11'h3FF, 11'h400, 11'h401, 11'($urandom), 11'h7F0};
		for (int p = 0; p < 6; p++) begin
			settle_block(DRAIN_WAIT);
			write_reg(REG_THRESHOLD, thr_pick[p]);
			write_reg(REG_BASELINE_SHIFT, {5'($urandom), shift_pick[p]});
			for (int ch = 0, sent = 0; sent < 50; ch++) begin
				noise = ($urandom_range(0, 99) < 20);
				len = noise ? $urandom_range(1, 12) : $urandom_range(1, 24);
				send_burst = ($urandom_range(0, 99) < 15);
				run_channel(len, noise, (ch == 0) ? len / 2 :
					($urandom_range(0, 9) == 0 ? $urandom_range(0, len - 1) : -1));
				sent += len;
			end
		end
		send_burst = 1'b0;

		settle_block(DRAIN_WAIT);
		$display("covered %0d samples in %0d channels across %0d register writes,",
			samples_sent, channels_sent, settings_used);
		$display("checked %0d results, %0d mismatches", results_checked, mismatches);
		if (mismatches == 0)
			$display("peak_zero_suppression_top_tb passed");
		else
			$display("peak_zero_suppression_top_tb failed");
		$finish;
	end

endmodule

// ----- peak_zero_suppression_top.f -----
design/pzs_pkg.sv
design/pzs_if.sv
design/pzs_queue.sv
design/pzs_front.sv
design/pzs_back.sv
design/peak_zero_suppression_top.sv
design/pzs_checker.sv
bench/peak_zero_suppression_top_tb.sv
